// ===== src/isim_pkg.sv =====
// ----------------------------------------------------------------------------
// isim_pkg
// Shared types and constants for the interval set insert/merge block.
// ----------------------------------------------------------------------------
package isim_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    // Field widths of the stream items.
    localparam int OPC_W    = 2;
    localparam int VAL_W    = 16;
    localparam int RIDX_W   = 4;
    localparam int RCNT_W   = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Width used to compare the read index against the range count.
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    // What an insert does to the table, decided by the search.
    typedef enum logic [1:0] {
        MD_NONE,
        MD_NEW,
        MD_OVF,
        MD_WIDEN
    } t_ins_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_APPLY,
        ST_MERGE,
        ST_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic latch;
        logic find;
        logic apply;
        logic merge;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_insert;
        logic widen;
        logic merge_go;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/isim_ctrl.sv =====
// ----------------------------------------------------------------------------
// isim_ctrl
// Sequencer: accept, search, apply, merge steps, result write.
// ----------------------------------------------------------------------------
module isim_ctrl
    import isim_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                n_state = i_sts.is_insert ? ST_APPLY : ST_DONE;
            end
            ST_APPLY: begin
                n_state = i_sts.widen ? ST_MERGE : ST_DONE;
            end
            ST_MERGE: begin
                if (!i_sts.merge_go) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.latch     = i_s_axis_tvalid;
            end
            ST_FIND: begin
                o_cmd.find = 1'b1;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            ST_MERGE: begin
                o_cmd.merge = i_sts.merge_go;
            end
            ST_DONE: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/isim_dp.sv =====
// ----------------------------------------------------------------------------
// isim_dp
// Range table, parallel search, shift/merge logic and the result register.
// ----------------------------------------------------------------------------
module isim_dp
    import isim_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    // Latched item.
    logic [OPC_W-1:0]         r_op;
    logic signed [VAL_W-1:0]  r_b;
    logic signed [VAL_W-1:0]  r_e;
    logic [RIDX_W-1:0]        r_idx;

    // Table and count.
    logic signed [VAL_W-1:0]  r_begin  [MAX_RANGES];
    logic signed [VAL_W-1:0]  r_finish [MAX_RANGES];
    logic signed [VAL_W-1:0]  n_begin  [MAX_RANGES];
    logic signed [VAL_W-1:0]  n_finish [MAX_RANGES];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    // Search outcome.
    t_ins_mode                r_mode;
    t_ins_mode                n_mode;
    logic [IDX_W-1:0]         r_pos;
    logic [CNT_W-1:0]         n_pos;
    logic                     r_set_b;
    logic                     r_set_e;

    // Result register.
    logic                     r_out_valid;
    logic [M_DATA_W-1:0]      r_out_data;
    logic [M_DATA_W-1:0]      n_out_data;

    // Search signals.
    logic                     found;
    logic                     sel_lt_e;
    logic                     sel_set_b;
    logic                     sel_set_e;
    logic [MAX_RANGES-1:0]    hit;
    logic [MAX_RANGES-1:0]    overlap_next;
    logic [MAX_RANGES-1:0]    grow_next;

    logic                     rd_ok;
    logic [CNT_W-1:0]         pos_plus;

    // Per-entry compares: each entry against the new begin and its next neighbor.
    always_comb begin
        for (int k = 0; k < MAX_RANGES; k++) begin
            hit[k] = (CNT_W'(k) < r_count) && !(r_b > r_finish[k]);
        end
        overlap_next = '0;
        grow_next    = '0;
        for (int k = 0; k < MAX_RANGES - 1; k++) begin
            overlap_next[k] = r_finish[k] >= r_begin[k+1];
            grow_next[k]    = r_finish[k+1] > r_finish[k];
        end
    end

    // First entry whose finish is not below the new begin.
    always_comb begin
        found     = 1'b0;
        sel_lt_e  = 1'b0;
        sel_set_b = 1'b0;
        sel_set_e = 1'b0;
        n_pos     = r_count;
        for (int k = 0; k < MAX_RANGES; k++) begin
            if (hit[k] && !found) begin
                found     = 1'b1;
                n_pos     = CNT_W'(k);
                sel_lt_e  = r_e < r_begin[k];
                sel_set_b = r_b < r_begin[k];
                sel_set_e = r_e > r_finish[k];
            end
        end
        if (!found || sel_lt_e) begin
            n_mode = (r_count >= CNT_W'(MAX_RANGES)) ? MD_OVF : MD_NEW;
        end else if (sel_set_b || sel_set_e) begin
            n_mode = MD_WIDEN;
        end else begin
            n_mode = MD_NONE;
        end
        if (r_op != OP_INSERT) begin
            n_mode = MD_NONE;
        end
    end

    assign pos_plus = CNT_W'(r_pos) + CNT_W'(1);

    // Table update.
    always_comb begin
        n_begin  = r_begin;
        n_finish = r_finish;
        n_count  = r_count;
        if (i_cmd.find && r_op == OP_CLEAR) begin
            n_count = '0;
        end
        if (i_cmd.apply && r_mode == MD_NEW) begin
            for (int k = 1; k < MAX_RANGES; k++) begin
                if (IDX_W'(k) > r_pos) begin
                    n_begin[k]  = r_begin[k-1];
                    n_finish[k] = r_finish[k-1];
                end
            end
            for (int k = 0; k < MAX_RANGES; k++) begin
                if (IDX_W'(k) == r_pos) begin
                    n_begin[k]  = r_b;
                    n_finish[k] = r_e;
                end
            end
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.apply && r_mode == MD_WIDEN) begin
            for (int k = 0; k < MAX_RANGES; k++) begin
                if (IDX_W'(k) == r_pos) begin
                    if (r_set_b) begin
                        n_begin[k] = r_b;
                    end
                    if (r_set_e) begin
                        n_finish[k] = r_e;
                    end
                end
            end
        end
        if (i_cmd.merge) begin
            // Absorb the next entry and close the gap it leaves.
            for (int k = 0; k < MAX_RANGES - 1; k++) begin
                if (IDX_W'(k) == r_pos) begin
                    if (grow_next[k]) begin
                        n_finish[k] = r_finish[k+1];
                    end
                end else if (IDX_W'(k) > r_pos) begin
                    n_begin[k]  = r_begin[k+1];
                    n_finish[k] = r_finish[k+1];
                end
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result fields.
    assign rd_ok = (r_op == OP_READ) && (CMP_W'(r_idx) < CMP_W'(r_count));

    always_comb begin
        n_out_data          = '0;
        n_out_data[0]       = (r_mode == MD_OVF);
        if (rd_ok) begin
            n_out_data[VAL_W:1]         = r_begin[IDX_W'(r_idx)];
            n_out_data[2*VAL_W:VAL_W+1] = r_finish[IDX_W'(r_idx)];
        end
        n_out_data[2*VAL_W+1]                      = rd_ok;
        n_out_data[2*VAL_W+1+RCNT_W:2*VAL_W+2]     = RCNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mode      <= MD_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.find) begin
                r_mode <= n_mode;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_begin  <= n_begin;
        r_finish <= n_finish;
        if (i_cmd.latch) begin
            r_op  <= i_s_axis_tdata[OPC_W-1:0];
            r_b   <= i_s_axis_tdata[OPC_W+VAL_W-1:OPC_W];
            r_e   <= i_s_axis_tdata[OPC_W+2*VAL_W-1:OPC_W+VAL_W];
            r_idx <= i_s_axis_tdata[OPC_W+2*VAL_W+RIDX_W-1:OPC_W+2*VAL_W];
        end
        if (i_cmd.find) begin
            r_pos   <= IDX_W'(n_pos);
            r_set_b <= sel_set_b;
            r_set_e <= sel_set_e;
        end
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_sts.is_insert = (r_op == OP_INSERT);
    assign o_sts.widen     = (r_mode == MD_WIDEN);
    assign o_sts.merge_go  = (pos_plus < r_count) && overlap_next[r_pos];
    assign o_sts.out_free  = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/interval_set_insert_merge.sv =====
// ----------------------------------------------------------------------------
// interval_set_insert_merge
// Sorted set of disjoint signed 16-bit ranges with insert, merge, read, clear.
// ----------------------------------------------------------------------------
// Steps: a read, a clear or an unused opcode passes from the search straight to
// the result write; an insert adds an apply step, and an insert that widens a
// range then adds a merge step for every stored range it merges away. The
// sequencer runs one step per cycle, but the result write waits while a result
// still sits in the output register, and no new item is taken meanwhile.
// Reset (synchronous, active low) empties the set; table contents are not cleared.
module interval_set_insert_merge
    import isim_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input item stream.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // Fields from bit 0: opcode[1:0], range_begin[17:2], range_end[33:18],
    // read_index[37:34], zero fill[39:38].
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // Result stream.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // Fields from bit 0: status[0], read_begin[16:1], read_finish[32:17],
    // read_valid[33], range_count[38:34], zero fill[39].
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    // The controller and the datapath exchange only these two groups.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The sequencer decides which step runs in each cycle. It takes an item
    // only when it is idle, so each item sees the table left by the one before.
    isim_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // The datapath holds the table in registers. The search compares the new
    // begin against every stored finish at once and picks the first match;
    // an insert then shifts the upper entries up, while a widen is followed by
    // merge steps that each absorb one neighbor that touches or overlaps.
    isim_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== test/interval_set_checker.sv =====
// ----------------------------------------------------------------------------
// interval_set_checker
// Watches both streams of the interval set block. It keeps its own ordered
// range table, predicts the result of every accepted item and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module interval_set_checker
    import isim_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    input  logic                i_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  logic                i_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    input  logic [M_DATA_W-1:0] i_m_axis_tdata,
    output int                  o_errors,
    output int                  o_pending
);

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic              status;
        t_val              lo;
        t_val              hi;
        logic              ok;
        logic [RCNT_W-1:0] count;
    } t_range_reply;

    // Model of the stored set, ascending and disjoint.
    t_val         lo_tab [MAX_RANGES];
    t_val         hi_tab [MAX_RANGES];
    int           range_total;
    t_range_reply range_op_results [$];
    int           fail_count;

    function automatic void drop_range(input int pos);
        for (int k = pos; k + 1 < range_total; k++) begin
            lo_tab[k] = lo_tab[k + 1];
            hi_tab[k] = hi_tab[k + 1];
        end
        range_total--;
    endfunction

    // Absorb following ranges that overlap or touch the range at pos.
    function automatic void absorb_after(input int pos);
        while (pos + 1 < range_total && hi_tab[pos] >= lo_tab[pos + 1]) begin
            if (hi_tab[pos + 1] > hi_tab[pos]) begin
                hi_tab[pos] = hi_tab[pos + 1];
            end
            drop_range(pos + 1);
        end
    endfunction

    // Returns 1 when a new entry was needed but the table is full.
    function automatic logic insert_range(input t_val b, input t_val e);
        int i;
        i = 0;
        while (i < range_total && b > hi_tab[i]) begin
            i++;
        end
        if (i >= range_total || e < lo_tab[i]) begin
            if (range_total >= MAX_RANGES) begin
                return 1'b1;
            end
            for (int k = range_total; k > i; k--) begin
                lo_tab[k] = lo_tab[k - 1];
                hi_tab[k] = hi_tab[k - 1];
            end
            lo_tab[i] = b;
            hi_tab[i] = e;
            range_total++;
        end else if (b < lo_tab[i]) begin
            lo_tab[i] = b;
            if (e > hi_tab[i]) begin
                hi_tab[i] = e;
            end
            absorb_after(i);
        end else if (e > hi_tab[i]) begin
            hi_tab[i] = e;
            absorb_after(i);
        end
        return 1'b0;
    endfunction

    function automatic t_range_reply apply_range_op(input logic [S_DATA_W-1:0] word);
        t_range_reply     r;
        logic [OPC_W-1:0] op;
        logic [RIDX_W-1:0] idx;
        op  = word[OPC_W-1:0];
        idx = word[OPC_W+2*VAL_W +: RIDX_W];
        r   = '0;
        if (op == OP_INSERT) begin
            r.status = insert_range(word[OPC_W +: VAL_W], word[OPC_W+VAL_W +: VAL_W]);
        end else if (op == OP_READ) begin
            if (int'(idx) < range_total) begin
                r.lo = lo_tab[idx];
                r.hi = hi_tab[idx];
                r.ok = 1'b1;
            end
        end else if (op == OP_CLEAR) begin
            range_total = 0;
        end
        r.count = RCNT_W'(range_total);
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_range_reply want;
        if (!i_rst_n) begin
            range_op_results.delete();
            range_total = 0;
            fail_count  = 0;
            foreach (lo_tab[k]) begin
                lo_tab[k] = '0;
                hi_tab[k] = '0;
            end
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                range_op_results.push_back(apply_range_op(i_s_axis_tdata));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (range_op_results.size() == 0) begin
                    $error("result transfer with no result pending: %h", i_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = range_op_results.pop_front();
                    check_field("status", int'(want.status), int'(i_m_axis_tdata[0]));
                    check_field("read_begin", int'(want.lo),
                                int'(t_val'(i_m_axis_tdata[1 +: VAL_W])));
                    check_field("read_finish", int'(want.hi),
                                int'(t_val'(i_m_axis_tdata[1+VAL_W +: VAL_W])));
                    check_field("read_valid", int'(want.ok),
                                int'(i_m_axis_tdata[1+2*VAL_W]));
                    check_field("range_count", int'(want.count),
                                int'(i_m_axis_tdata[2+2*VAL_W +: RCNT_W]));
                end
            end
        end
        o_errors  <= fail_count;
        o_pending <= range_op_results.size();
    end

endmodule

// ===== test/tb_interval_set_insert_merge.sv =====
// ----------------------------------------------------------------------------
// tb_interval_set_insert_merge
// Drives insert, read, clear and unused-opcode items into the interval set
// block with random idling on both streams, and reports the verdict from the
// failure count of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_interval_set_insert_merge;
    import isim_pkg::*;

    // The opcode value that the block treats as a no-op.
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // Number of random items, and how many at the end run without idling.
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_ITEMS   = 80;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // Fields from bit 0: opcode, range_begin, range_end, read_index, zero fill.
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // Fields from bit 0: status, read_begin, read_finish, read_valid, range_count.
    logic [M_DATA_W-1:0] m_tdata;

    int   errors;
    int   pending;
    logic calm = 1'b0;
    int   ready_hold = 0;
    int   items_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    interval_set_insert_merge u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    interval_set_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // The result side alternates between ready stretches and stall bursts at
    // random. Once the run turns calm it stays ready for good.
    always @(posedge i_clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (ready_hold == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 12);
            end else begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 30);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Presents one item and returns at the edge where its transfer happens.
    // An optional idle burst comes first; tvalid is only lowered when a gap
    // follows, so back-to-back items keep it high without a glitch.
    task automatic transfer_item(input logic [OPC_W-1:0] op,
                                 input logic signed [VAL_W-1:0] b,
                                 input logic signed [VAL_W-1:0] e,
                                 input logic [RIDX_W-1:0] idx);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-OPC_W-2*VAL_W-RIDX_W){1'b0}}, idx, e, b, op};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    // Fields that an operation ignores still carry random bits.
    task automatic add_range(input logic signed [VAL_W-1:0] b,
                             input logic signed [VAL_W-1:0] e);
        transfer_item(OP_INSERT, b, e, RIDX_W'($urandom));
    endtask

    task automatic read_at(input int idx);
        transfer_item(OP_READ, VAL_W'($urandom), VAL_W'($urandom), RIDX_W'(idx));
    endtask

    task automatic clear_all();
        transfer_item(OP_CLEAR, VAL_W'($urandom), VAL_W'($urandom), RIDX_W'($urandom));
    endtask

    initial begin
        int                      pick;
        int                      span;
        int                      stride;
        int                      count;
        int                      slot;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] e;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part. An unused opcode and a read of the empty set first.
        transfer_item(OP_UNUSED, VAL_W'($urandom), VAL_W'($urandom), RIDX_W'($urandom));
        read_at(0);
        // Single-point ranges at both ends of the value range.
        add_range(VAL_MIN, VAL_MIN);
        add_range(VAL_MAX, VAL_MAX);
        // Two ranges joined by a third that only shares their endpoints.
        add_range(0, 10);
        add_range(20, 30);
        add_range(10, 20);
        // A range that widens the one below it until it overlaps the next.
        add_range(-5, -1);
        add_range(-3, 5);
        // Reversed range and a neighbor one value apart, then read back.
        add_range(40, 35);
        add_range(-8, -6);
        read_at(2);
        read_at(15);
        // One range covering all values swallows the whole set.
        add_range(VAL_MIN, VAL_MAX);
        read_at(0);
        clear_all();
        // Fill the table from the top down so every insert after the first shifts entries.
        for (int k = MAX_RANGES - 1; k >= 0; k--) begin
            add_range(VAL_W'(k * 100), VAL_W'(k * 100 + 10));
        end
        // A new range on a full table overflows, a widening one does not.
        add_range(5000, 5001);
        add_range(0, 50);
        read_at(MAX_RANGES - 1);

        // Random part, built from short well-formed sequences plus noise.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                calm <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // Dense window: many inserts close together so that
                // widening, merging and touching endpoints are common.
                base  = VAL_W'($urandom);
                span  = $urandom_range(4, 200);
                count = $urandom_range(6, 20);
                for (int k = 0; k < count; k++) begin
                    b = VAL_W'(base + $urandom_range(0, span));
                    if ($urandom_range(0, 9) == 0) begin
                        e = VAL_W'(b - $urandom_range(1, 8));
                    end else begin
                        e = VAL_W'(b + $urandom_range(0, span / 4));
                    end
                    add_range(b, e);
                    if ($urandom_range(0, 6) == 0) begin
                        read_at($urandom_range(0, MAX_RANGES - 1));
                    end
                end
            end else if (pick < 65) begin
                // Fill: disjoint slots on a grid, at least as many inserts as the table
                // holds, then a sweep over every index.
                clear_all();
                base   = VAL_W'($urandom);
                stride = $urandom_range(8, 2600);
                count  = $urandom_range(MAX_RANGES, MAX_RANGES + 8);
                for (int k = 0; k < count; k++) begin
                    slot = $urandom_range(0, 23);
                    b    = VAL_W'(base + slot * stride);
                    e    = VAL_W'(b + $urandom_range(0, stride / 2));
                    add_range(b, e);
                end
                for (int k = 0; k < MAX_RANGES; k++) begin
                    read_at(k);
                end
            end else if (pick < 80) begin
                // Noise: every field random, the unused opcode included.
                count = $urandom_range(3, 10);
                for (int k = 0; k < count; k++) begin
                    transfer_item(OPC_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                                  RIDX_W'($urandom));
                end
            end else if (pick < 92) begin
                count = $urandom_range(1, 8);
                for (int k = 0; k < count; k++) begin
                    read_at($urandom_range(0, MAX_RANGES - 1));
                end
            end else begin
                clear_all();
            end
        end
        s_tvalid <= 1'b0;

        // Let the last transfer reach the checker, drain, then settle.
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (32) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
